[rtl/lfdd_pkg.sv]
// Shared widths, constants, register codes and handshake structs for the line-follow drive.
package lfdd_pkg;

	// fixed field widths
	localparam int BASE_W     = 8;
	localparam int GAIN_W     = 12;
	localparam int KP_W       = 10;
	localparam int LIM_W      = 8;
	localparam int PER_W      = 16;
	localparam int COUNT_W    = 16;
	localparam int HEAD_W     = 17;
	localparam int DUTY_W     = 8;
	localparam int ERR_W      = 24;
	localparam int SUM_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// x/3 for 16-bit x: (x * 43691) >> 17, exact
	localparam int              DIV3_M_W = 17;
	localparam logic [16:0]     DIV3_MUL = 17'd43691;
	localparam int              DIV3_SH  = 17;

	// x/100 for 16-bit x: (x * 83887) >> 23, exact
	localparam int              DIV100_M_W = 17;
	localparam logic [16:0]     DIV100_MUL = 17'd83887;
	localparam int              DIV100_SH  = 23;
	localparam int              P100_W     = 10;

	// register reset values
	localparam logic [BASE_W-1:0] BASE_RST = 8'd20;
	localparam logic [GAIN_W-1:0] GAIN_RST = 12'd870;
	localparam logic [KP_W-1:0]   KP_RST   = 10'd230;
	localparam logic [LIM_W-1:0]  LIM_RST  = 8'd200;
	localparam logic [PER_W-1:0]  PER_RST  = 16'd2500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_SPEED  = 3'd0,
		REG_STEER_GAIN  = 3'd1,
		REG_SPEED_KP    = 3'd2,
		REG_DRIVE_LIMIT = 3'd3,
		REG_PWM_PERIOD  = 3'd4
	} cfg_reg_t;

	// start / release of a sub-unit
	typedef struct packed {
		logic start;
		logic take;
	} unit_ctrl_t;

	// one wheel's result
	typedef struct packed {
		logic              forward;
		logic [DUTY_W-1:0] duty;
		logic [PER_W-1:0]  compare;
	} wheel_res_t;

endpackage

[rtl/line_follow_differential_drive.sv]
// Top level: config registers, steering unit, two wheel lanes and the merging output register.
//
//  channel | signals                                            | dir | beat when
//  --------+----------------------------------------------------+-----+---------------------
//  in      | in_valid, in_stall, line_sensors, left_count,      | in  | in_valid & !in_stall
//          | right_count, heading_bias, use_heading             |     |
//  out     | out_valid, out_stall, left_/right_forward,         | out | out_valid & !out_stall
//          | left_/right_duty, left_/right_compare, line_lost   |     |
//  cfg     | cfg_wr_en, cfg_index, cfg_data                     | in  | cfg_wr_en
//
// One beat in flight; the sensor scan and the bit-serial centroid divider set the cycle count.
// Centroid mode: sensor scan, gain multiply, PM_W-bit bit-serial divide, target, hand-over,
// the lane steps (div3, error, multiply, accumulate, duty, compare) and the merge into the
// output register. Heading mode skips the scan, multiply and divide.
// Async reset clears config to defaults and both loop states to zero. An input beat is taken
// while a result waits at the output; a finished result that cannot enter it holds the lanes.
module line_follow_differential_drive
	import lfdd_pkg::*;
#(
	parameter int SENSOR_COUNT = 8,
	parameter int FRAC_BITS    = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input channel
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SENSOR_COUNT-1:0]  line_sensors,
	input  logic signed [COUNT_W-1:0] left_count,
	input  logic signed [COUNT_W-1:0] right_count,
	input  logic signed [HEAD_W-1:0] heading_bias,
	input  logic                     use_heading,
	// output channel
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     left_forward,
	output logic [DUTY_W-1:0]        left_duty,
	output logic [PER_W-1:0]         left_compare,
	output logic                     right_forward,
	output logic [DUTY_W-1:0]        right_duty,
	output logic [PER_W-1:0]         right_compare,
	output logic                     line_lost,
	// config
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	// centroid arithmetic widths
	localparam int IDX_W  = $clog2(SENSOR_COUNT);
	localparam int MAG_W  = $clog2(SENSOR_COUNT * SENSOR_COUNT / 4 + 1);
	localparam int WS_W   = ((MAG_W > IDX_W + 1) ? MAG_W : IDX_W + 1) + 1;
	localparam int PM_W   = WS_W - 1 + GAIN_W;
	localparam int BIAS_W = ((PM_W > HEAD_W) ? PM_W : HEAD_W) + 1;
	localparam int BFX_W  = BASE_W + FRAC_BITS + 1;
	localparam int TGT_W  = ((BIAS_W > BFX_W) ? BIAS_W : BFX_W) + 1;

	typedef enum logic [1:0] {
		T_IDLE, T_STEER, T_WHEEL
	} st_t;

	st_t                      state_q;
	logic [BASE_W-1:0]        base_q;
	logic [GAIN_W-1:0]        gain_q;
	logic [KP_W-1:0]          kp_q;
	logic [LIM_W-1:0]         lim_q;
	logic [PER_W-1:0]         per_q;
	logic signed [COUNT_W-1:0] lcount_q;
	logic signed [COUNT_W-1:0] rcount_q;

	logic                     out_valid_q;
	wheel_res_t               lres_q;
	wheel_res_t               rres_q;
	logic                     lost_q;

	unit_ctrl_t               steer_ctrl;
	unit_ctrl_t               lane_ctrl;
	logic                     steer_done;
	logic signed [TGT_W-1:0]  target_l;
	logic signed [TGT_W-1:0]  target_r;
	logic                     steer_lost;
	logic                     l_done;
	logic                     r_done;
	wheel_res_t               l_res;
	wheel_res_t               r_res;

	logic                     accept;
	logic                     lanes_go;
	logic                     merge;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid & ~in_stall;
	assign lanes_go = (state_q == T_STEER) & steer_done;
	// merge both lanes once the output register is free or being emptied
	assign merge    = (state_q == T_WHEEL) & l_done & r_done & (~out_valid_q | ~out_stall);

	assign steer_ctrl = '{start: accept, take: lanes_go};
	assign lane_ctrl  = '{start: lanes_go, take: merge};

	// config registers, written straight from the port at the write edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RST;
			gain_q <= GAIN_RST;
			kp_q   <= KP_RST;
			lim_q  <= LIM_RST;
			per_q  <= PER_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_SPEED:  base_q <= cfg_data[BASE_W-1:0];
				REG_STEER_GAIN:  gain_q <= cfg_data[GAIN_W-1:0];
				REG_SPEED_KP:    kp_q   <= cfg_data[KP_W-1:0];
				REG_DRIVE_LIMIT: lim_q  <= cfg_data[LIM_W-1:0];
				REG_PWM_PERIOD:  per_q  <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			lcount_q    <= '0;
			rcount_q    <= '0;
			out_valid_q <= 1'b0;
			lres_q      <= '0;
			rres_q      <= '0;
			lost_q      <= 1'b0;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						lcount_q <= left_count;
						rcount_q <= right_count;
						state_q  <= T_STEER;
					end
				end
				T_STEER: begin
					if (lanes_go) begin
						state_q <= T_WHEEL;
					end
				end
				T_WHEEL: begin
					if (merge) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase

			if (merge) begin
				out_valid_q <= 1'b1;
				lres_q      <= l_res;
				rres_q      <= r_res;
				lost_q      <= steer_lost;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	lfdd_steer #(
		.SENSOR_COUNT (SENSOR_COUNT),
		.FRAC_BITS    (FRAC_BITS),
		.WS_W         (WS_W),
		.TGT_W        (TGT_W)
	) u_steer (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (steer_ctrl),
		.sensors     (line_sensors),
		.heading     (heading_bias),
		.use_heading (use_heading),
		.base        (base_q),
		.gain        (gain_q),
		.done        (steer_done),
		.target_l    (target_l),
		.target_r    (target_r),
		.lost        (steer_lost)
	);

	lfdd_wheel #(
		.FRAC_BITS (FRAC_BITS),
		.TGT_W     (TGT_W)
	) u_wheel_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.target (target_l),
		.count  (lcount_q),
		.kp     (kp_q),
		.lim    (lim_q),
		.period (per_q),
		.done   (l_done),
		.res    (l_res)
	);

	lfdd_wheel #(
		.FRAC_BITS (FRAC_BITS),
		.TGT_W     (TGT_W)
	) u_wheel_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lane_ctrl),
		.target (target_r),
		.count  (rcount_q),
		.kp     (kp_q),
		.lim    (lim_q),
		.period (per_q),
		.done   (r_done),
		.res    (r_res)
	);

	assign out_valid     = out_valid_q;
	assign left_forward  = lres_q.forward;
	assign left_duty     = lres_q.duty;
	assign left_compare  = lres_q.compare;
	assign right_forward = rres_q.forward;
	assign right_duty    = rres_q.duty;
	assign right_compare = rres_q.compare;
	assign line_lost     = lost_q;

endmodule

[rtl/lfdd_steer.sv]
// Steering unit: sensor centroid scan, gain multiply, bit-serial divide (or heading bias), wheel targets.
module lfdd_steer
	import lfdd_pkg::*;
#(
	parameter int SENSOR_COUNT = 8,
	parameter int FRAC_BITS    = 8,
	parameter int WS_W         = 6,
	parameter int TGT_W        = 19
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  unit_ctrl_t               ctrl,
	input  logic [SENSOR_COUNT-1:0]  sensors,
	input  logic signed [HEAD_W-1:0] heading,
	input  logic                     use_heading,
	input  logic [BASE_W-1:0]        base,
	input  logic [GAIN_W-1:0]        gain,
	output logic                     done,
	output logic signed [TGT_W-1:0]  target_l,
	output logic signed [TGT_W-1:0]  target_r,
	output logic                     lost
);

	localparam int IDX_W  = $clog2(SENSOR_COUNT);
	localparam int CNT_W  = $clog2(SENSOR_COUNT + 1);
	localparam int PM_W   = WS_W - 1 + GAIN_W;
	localparam int BIAS_W = ((PM_W > HEAD_W) ? PM_W : HEAD_W) + 1;
	localparam int DC_W   = $clog2(PM_W);
	localparam int BFX_W  = BASE_W + FRAC_BITS + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_MUL, S_DIV, S_FIN, S_DONE
	} st_t;

	st_t                      state_q;
	logic [SENSOR_COUNT-1:0]  sens_q;
	logic signed [HEAD_W-1:0] head_q;
	logic                     use_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [WS_W-1:0]   wsum_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     neg_q;
	logic [PM_W-1:0]          quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic [DC_W-1:0]          dc_q;
	logic signed [TGT_W-1:0]  tl_q;
	logic signed [TGT_W-1:0]  tr_q;
	logic                     lost_q;

	logic signed [WS_W-1:0]   weight;
	logic signed [WS_W-1:0]   wneg;
	logic [WS_W-2:0]          wabs;
	logic [PM_W-1:0]          pm;
	logic [CNT_W:0]           rtrial;
	logic [CNT_W:0]           rsub;
	logic                     ge;
	logic signed [BIAS_W-1:0] mag_ext;
	logic signed [BIAS_W-1:0] bias;
	logic signed [BFX_W-1:0]  base_fx;

	always_comb begin
		// sensor i weighs 2i-(N-1)
		weight  = WS_W'($signed({1'b0, idx_q, 1'b0})) - WS_W'(SENSOR_COUNT - 1);
		wneg    = -wsum_q;
		wabs    = wsum_q[WS_W-1] ? wneg[WS_W-2:0] : wsum_q[WS_W-2:0];
		pm      = {{GAIN_W{1'b0}}, wabs} * {{(WS_W-1){1'b0}}, gain};
		rtrial  = {rem_q, quo_q[PM_W-1]};
		ge      = (rtrial >= {1'b0, cnt_q});
		rsub    = rtrial - {1'b0, cnt_q};
		mag_ext = $signed({{(BIAS_W-PM_W){1'b0}}, quo_q});
		if (use_q) begin
			bias = BIAS_W'(head_q);
		end else if (cnt_q == '0) begin
			bias = '0;
		end else begin
			bias = neg_q ? -mag_ext : mag_ext;
		end
		base_fx = $signed({1'b0, base, {FRAC_BITS{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sens_q  <= '0;
			head_q  <= '0;
			use_q   <= 1'b0;
			idx_q   <= '0;
			wsum_q  <= '0;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			quo_q   <= '0;
			rem_q   <= '0;
			dc_q    <= '0;
			tl_q    <= '0;
			tr_q    <= '0;
			lost_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						sens_q  <= sensors;
						head_q  <= heading;
						use_q   <= use_heading;
						idx_q   <= '0;
						wsum_q  <= '0;
						cnt_q   <= '0;
						state_q <= use_heading ? S_FIN : S_SCAN;
					end
				end
				S_SCAN: begin
					if (sens_q[idx_q]) begin
						wsum_q <= wsum_q + weight;
						cnt_q  <= cnt_q + 1'b1;
					end
					if (idx_q == IDX_W'(SENSOR_COUNT - 1)) begin
						state_q <= S_MUL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_MUL: begin
					// bias = -(wsum*gain)/cnt: sign opposite to the centroid
					quo_q   <= pm;
					neg_q   <= ~wsum_q[WS_W-1];
					rem_q   <= '0;
					dc_q    <= '0;
					state_q <= (cnt_q == '0) ? S_FIN : S_DIV;
				end
				S_DIV: begin
					quo_q <= {quo_q[PM_W-2:0], ge};
					rem_q <= ge ? rsub[CNT_W-1:0] : rtrial[CNT_W-1:0];
					if (dc_q == DC_W'(PM_W - 1)) begin
						state_q <= S_FIN;
					end else begin
						dc_q <= dc_q + 1'b1;
					end
				end
				S_FIN: begin
					tl_q    <= TGT_W'(base_fx) + TGT_W'(bias);
					tr_q    <= TGT_W'(base_fx) - TGT_W'(bias);
					lost_q  <= ~use_q & (cnt_q == '0);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctrl.take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done     = (state_q == S_DONE);
	assign target_l = tl_q;
	assign target_r = tr_q;
	assign lost     = lost_q;

endmodule

[rtl/lfdd_wheel.sv]
// Wheel lane: speed from count, incremental P loop, clamp, duty and timer compare.
module lfdd_wheel
	import lfdd_pkg::*;
#(
	parameter int FRAC_BITS = 8,
	parameter int TGT_W     = 19
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  unit_ctrl_t                ctrl,
	input  logic signed [TGT_W-1:0]   target,
	input  logic signed [COUNT_W-1:0] count,
	input  logic [KP_W-1:0]           kp,
	input  logic [LIM_W-1:0]          lim,
	input  logic [PER_W-1:0]          period,
	output logic                      done,
	output wheel_res_t                res
);

	localparam int SPD_W = COUNT_W + FRAC_BITS;
	localparam int DA_W  = (TGT_W > SPD_W + 1) ? TGT_W : SPD_W + 1;
	localparam int DIF_W = ((DA_W > ERR_W) ? DA_W : ERR_W) + 1;
	localparam int PRD_W = ERR_W + 1 + KP_W + 1;
	localparam int ACC_W = PRD_W + 1;
	localparam int PD_W  = P100_W + DUTY_W;
	localparam logic [FRAC_BITS-1:0] THIRD1 = FRAC_BITS'((1 << FRAC_BITS) / 3);
	localparam logic [FRAC_BITS-1:0] THIRD2 = FRAC_BITS'((2 << FRAC_BITS) / 3);
	localparam logic signed [DIF_W-1:0] EMAX = DIF_W'({1'b0, {(ERR_W-1){1'b1}}});
	localparam logic signed [DIF_W-1:0] EMIN = ~EMAX;
	localparam logic signed [ACC_W-1:0] SMAX = ACC_W'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0] SMIN = ~SMAX;
	localparam logic signed [PRD_W-1:0] RND  = PRD_W'({FRAC_BITS{1'b1}});

	typedef enum logic [2:0] {
		L_IDLE, L_DIV3, L_ERR, L_MUL, L_ACC, L_DUTY, L_CMP, L_DONE
	} st_t;

	st_t                      state_q;
	logic [COUNT_W-1:0]       q_q;
	logic [P100_W-1:0]        p100_q;
	logic signed [ERR_W-1:0]  err_q;
	logic signed [ERR_W-1:0]  prev_q;
	logic signed [PRD_W-1:0]  prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	wheel_res_t               res_q;

	logic [COUNT_W-1:0]                 a_mag;
	logic [COUNT_W+DIV3_M_W-1:0]        q3_full;
	logic [PER_W+DIV100_M_W-1:0]        p100_full;
	logic [COUNT_W-1:0]                 r_full;
	logic [FRAC_BITS-1:0]               frac;
	logic signed [SPD_W:0]              spd;
	logic signed [DIF_W-1:0]            diff;
	logic signed [ERR_W-1:0]            err_sat;
	logic signed [ERR_W:0]              de;
	logic signed [PRD_W-1:0]            prod;
	logic signed [PRD_W-1:0]            inc;
	logic signed [ACC_W-1:0]            acc;
	logic signed [SUM_W-1:0]            sum_sat;
	logic [SUM_W-1:0]                   smag;
	logic [SUM_W-1:0]                   shr;
	logic [DUTY_W-1:0]                  duty;
	logic [PD_W-1:0]                    pd;
	logic [PER_W-1:0]                   cmp;

	always_comb begin
		a_mag     = count[COUNT_W-1] ? (-count) : count;
		q3_full   = {{DIV3_M_W{1'b0}}, a_mag} * {{COUNT_W{1'b0}}, DIV3_MUL};
		p100_full = {{DIV100_M_W{1'b0}}, period} * {{PER_W{1'b0}}, DIV100_MUL};

		// speed = count*ONE/3 = q*ONE + (r*ONE)/3 on the magnitude
		r_full = a_mag - (q_q + {q_q[COUNT_W-2:0], 1'b0});
		case (r_full[1:0])
			2'd1:    frac = THIRD1;
			2'd2:    frac = THIRD2;
			default: frac = '0;
		endcase
		spd  = count[COUNT_W-1] ? -$signed({1'b0, q_q, frac}) : $signed({1'b0, q_q, frac});
		diff = DIF_W'(target) - DIF_W'(spd);
		if (diff > EMAX) begin
			err_sat = EMAX[ERR_W-1:0];
		end else if (diff < EMIN) begin
			err_sat = EMIN[ERR_W-1:0];
		end else begin
			err_sat = diff[ERR_W-1:0];
		end

		de   = (ERR_W+1)'(err_q) - (ERR_W+1)'(prev_q);
		prod = $signed({1'b0, kp}) * de;

		// divide by ONE toward zero
		inc = (prod_q[PRD_W-1] ? (prod_q + RND) : prod_q) >>> FRAC_BITS;
		acc = ACC_W'(sum_q) + ACC_W'(inc);
		if (acc > SMAX) begin
			sum_sat = SMAX[SUM_W-1:0];
		end else if (acc < SMIN) begin
			sum_sat = SMIN[SUM_W-1:0];
		end else begin
			sum_sat = acc[SUM_W-1:0];
		end

		// |clamp(sum)|/ONE == min(|sum|/ONE, limit)
		smag = sum_q[SUM_W-1] ? (-sum_q) : sum_q;
		shr  = smag >> FRAC_BITS;
		duty = (shr > SUM_W'(lim)) ? lim : shr[DUTY_W-1:0];

		pd = {{DUTY_W{1'b0}}, p100_q} * {{P100_W{1'b0}}, res_q.duty};
		if (PD_W'(period) >= pd) begin
			cmp = period - pd[PER_W-1:0];
		end else begin
			cmp = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			q_q     <= '0;
			p100_q  <= '0;
			err_q   <= '0;
			prev_q  <= '0;
			prod_q  <= '0;
			sum_q   <= '0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (ctrl.start) begin
						state_q <= L_DIV3;
					end
				end
				L_DIV3: begin
					q_q     <= q3_full[DIV3_SH +: COUNT_W];
					p100_q  <= p100_full[DIV100_SH +: P100_W];
					state_q <= L_ERR;
				end
				L_ERR: begin
					err_q   <= err_sat;
					state_q <= L_MUL;
				end
				L_MUL: begin
					prod_q  <= prod;
					state_q <= L_ACC;
				end
				L_ACC: begin
					sum_q   <= sum_sat;
					prev_q  <= err_q;
					state_q <= L_DUTY;
				end
				L_DUTY: begin
					res_q.duty    <= duty;
					res_q.forward <= ~sum_q[SUM_W-1] & (duty != '0);
					state_q       <= L_CMP;
				end
				L_CMP: begin
					res_q.compare <= cmp;
					state_q       <= L_DONE;
				end
				L_DONE: begin
					if (ctrl.take) begin
						state_q <= L_IDLE;
					end
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done = (state_q == L_DONE);
	assign res  = res_q;

endmodule
